// ===== rtl/fmmn_pkg.sv =====
// ----------------------------------------------------------------------------
// fmmn_pkg
// shared constants and types of the frame min-max normalizer
// ----------------------------------------------------------------------------
package fmmn_pkg;

	localparam int FRAME_LEN_DEF     = 1024;
	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;

	// work queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [QUEUE_LVL_W-1:0] level;
		logic                   empty;
	} fmmn_qstat_t;

endpackage

// ===== rtl/fmmn_ifs.sv =====
// ----------------------------------------------------------------------------
// fmmn channel interfaces
// valid/ready channels for input samples and normalized results
// ----------------------------------------------------------------------------
interface fmmn_sample_if
	import fmmn_pkg::*;
	#(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);

endinterface

interface fmmn_norm_if
	import fmmn_pkg::*;
	#(parameter int FRACTION_BITS = FRACTION_BITS_DEF) ();

	logic                   valid;
	logic                   ready;
	logic [FRACTION_BITS:0] normalized;
	logic                   frame_last;

	modport source (output valid, output normalized, output frame_last, input ready);
	modport sink (input valid, input normalized, input frame_last, output ready);

endinterface

// ===== rtl/fmmn_ram.sv =====
// ----------------------------------------------------------------------------
// fmmn_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fmmn_ram
	import fmmn_pkg::*;
	#(
	parameter int WIDTH = SAMPLE_BITS_DEF,
	parameter int DEPTH = 2 * FRAME_LEN_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/fmmn_front.sv =====
// ----------------------------------------------------------------------------
// fmmn_front
// stores samples into the ping-pong banks, tracks min/max, reads back the
// previous frame and hands work items to the queue
// ----------------------------------------------------------------------------
module fmmn_front
	import fmmn_pkg::*;
	#(
	parameter int FRAME_LEN   = FRAME_LEN_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fmmn_sample_if.sink                samples,
	input  fmmn_qstat_t                qstat,
	output logic                       push,
	output logic [3*SAMPLE_BITS:0]     push_data
);

	localparam int PW = $clog2(FRAME_LEN);
	localparam int AW = $clog2(2 * FRAME_LEN);

	logic [PW-1:0]                 wpos_q;
	logic                          bank_q;
	logic                          prev_rdy_q;
	logic signed [SAMPLE_BITS-1:0] run_min_q, run_max_q;
	logic signed [SAMPLE_BITS-1:0] frm_min_q, frm_max_q;

	logic                          vld_s1;
	logic                          last_s1;
	logic signed [SAMPLE_BITS-1:0] min_s1, max_s1;

	logic                          accept;
	logic                          last;
	logic signed [SAMPLE_BITS-1:0] nxt_min, nxt_max;
	logic [AW-1:0]                 waddr, raddr;
	logic [SAMPLE_BITS-1:0]        rdata;

	// keep room for the item whose bank read is still in flight
	assign samples.ready = ({1'b0, qstat.level} + (QUEUE_LVL_W + 1)'(vld_s1))
		< (QUEUE_LVL_W + 1)'(QUEUE_DEPTH);
	assign accept = samples.valid && samples.ready;
	assign last   = (wpos_q == PW'(FRAME_LEN - 1));

	assign waddr = bank_q ? (AW'(wpos_q) + AW'(FRAME_LEN)) : AW'(wpos_q);
	assign raddr = bank_q ? AW'(wpos_q) : (AW'(wpos_q) + AW'(FRAME_LEN));

	always_comb begin
		if (wpos_q == '0) begin
			nxt_min = samples.sample;
			nxt_max = samples.sample;
		end else begin
			nxt_min = (samples.sample < run_min_q) ? samples.sample : run_min_q;
			nxt_max = (samples.sample > run_max_q) ? samples.sample : run_max_q;
		end
	end

	fmmn_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (2 * FRAME_LEN)
	) u_banks (
		.clk   (clk),
		.we    (accept),
		.waddr (waddr),
		.wdata (samples.sample),
		.re    (accept && prev_rdy_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q     <= '0;
			bank_q     <= 1'b0;
			prev_rdy_q <= 1'b0;
			run_min_q  <= '0;
			run_max_q  <= '0;
			frm_min_q  <= '0;
			frm_max_q  <= '0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= accept && prev_rdy_q;
			if (accept) begin
				run_min_q <= nxt_min;
				run_max_q <= nxt_max;
				if (last) begin
					frm_min_q  <= nxt_min;
					frm_max_q  <= nxt_max;
					bank_q     <= ~bank_q;
					prev_rdy_q <= 1'b1;
					wpos_q     <= '0;
				end else begin
					wpos_q <= wpos_q + 1'b1;
				end
			end
		end
	end

	// extremes of the frame being read out, taken before the boundary update
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last;
			min_s1  <= frm_min_q;
			max_s1  <= frm_max_q;
		end
	end

	assign push      = vld_s1;
	assign push_data = {rdata, min_s1, max_s1, last_s1};

endmodule

// ===== rtl/fmmn_queue.sv =====
// ----------------------------------------------------------------------------
// fmmn_queue
// small register fifo of work items between front and back
// ----------------------------------------------------------------------------
module fmmn_queue
	import fmmn_pkg::*;
	#(
	parameter int WIDTH = 3 * SAMPLE_BITS_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output fmmn_qstat_t      qstat
);

	localparam int QAW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0]       slot_q [QUEUE_DEPTH];
	logic [QAW-1:0]         wr_ptr_q, rd_ptr_q;
	logic [QUEUE_LVL_W-1:0] level_q;

	assign head        = slot_q[rd_ptr_q];
	assign qstat.level = level_q;
	assign qstat.empty = (level_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/fmmn_back.sv =====
// ----------------------------------------------------------------------------
// fmmn_back
// radix-2 restoring divider producing (sample - min) * 2^fb / range,
// followed by the result output register
// ----------------------------------------------------------------------------
module fmmn_back
	import fmmn_pkg::*;
	#(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [3*SAMPLE_BITS:0] head,
	input  fmmn_qstat_t            qstat,
	output logic                   pop,
	fmmn_norm_if.source            results
);

	localparam int SB = SAMPLE_BITS;
	localparam int FB = FRACTION_BITS;
	localparam int CW = $clog2(FB + 1);

	logic signed [SB-1:0] h_smp, h_lo, h_hi;
	logic                 h_last;
	logic [SB:0]          range_full, diff_full;
	logic [SB-1:0]        range, diff_raw, diff;

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [SB:0]   rem_q;
	logic [SB-1:0] div_q;
	logic [FB-1:0] quo_q;
	logic          last_q;

	logic          ge;
	logic [SB:0]   sub;
	logic [FB:0]   quo_nxt;
	logic          final_step, can_load, step;

	logic          ovld_q;
	logic [FB:0]   norm_q;
	logic          olast_q;

	assign h_smp  = head[3*SB:2*SB+1];
	assign h_lo   = head[2*SB:SB+1];
	assign h_hi   = head[SB:1];
	assign h_last = head[0];

	// operand setup from the queue head
	assign range_full = {h_hi[SB-1], h_hi} - {h_lo[SB-1], h_lo};
	assign range      = (range_full[SB-1:0] == '0) ? SB'(1) : range_full[SB-1:0];
	assign diff_full  = {h_smp[SB-1], h_smp} - {h_lo[SB-1], h_lo};
	assign diff_raw   = (h_smp > h_lo) ? diff_full[SB-1:0] : '0;
	assign diff       = (diff_raw > range) ? range : diff_raw;

	assign pop = !busy_q && !qstat.empty;

	// one quotient bit per cycle while busy; the last bit waits until the output register can load
	assign ge         = rem_q >= {1'b0, div_q};
	assign sub        = rem_q - (ge ? {1'b0, div_q} : '0);
	assign quo_nxt    = {quo_q, ge};
	assign final_step = busy_q && (cnt_q == '0);
	assign can_load   = !ovld_q || results.ready;
	assign step       = busy_q && (!final_step || can_load);

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q  <= {1'b0, diff};
			div_q  <= range;
			quo_q  <= '0;
			last_q <= h_last;
		end else if (step) begin
			rem_q <= {sub[SB-1:0], 1'b0};
			quo_q <= quo_nxt[FB-1:0];
		end
		if (final_step && can_load) begin
			norm_q  <= quo_nxt;
			olast_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(FB);
			end else if (step) begin
				if (final_step) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (final_step && can_load) begin
				ovld_q <= 1'b1;
			end else if (results.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	assign results.valid      = ovld_q;
	assign results.normalized = norm_q;
	assign results.frame_last = olast_q;

endmodule

// ===== rtl/frame_min_max_normalizer.sv =====
// ----------------------------------------------------------------------------
// frame_min_max_normalizer
// per-frame min-max normalization of signed audio samples with one frame of
// latency through two alternating buffer banks
// ----------------------------------------------------------------------------
//
// channel   role    payload                          transaction
// samples   sink    sample[SAMPLE_BITS-1:0] signed   one pcm sample stored
// results   source  normalized[FRACTION_BITS:0],     one sample of the
//                   frame_last                       previous frame
//
// the bit-serial divider in the back end loads a work item, then produces one
//   quotient bit per cycle, the last once the output register can load; it takes
//   a new item only after the last one is finished
// the front end takes one sample per cycle until the work queue fills; no
//   result comes out while the first frame after reset is being stored
// reset: arst_n clears positions, bank select, extremes, the queue and all
//   valid flags; bank contents are not cleared and need no clearing pass
// stalls: a stalled results channel holds the output register and then the
//   divider; the queue absorbs the difference until samples.ready drops
//
module frame_min_max_normalizer
	import fmmn_pkg::*;
	#(
	parameter int FRAME_LEN     = FRAME_LEN_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fmmn_sample_if.sink   samples,
	fmmn_norm_if.source   results
);

	// work item: bank sample, frame min, frame max, last flag
	localparam int ITEM_W = 3 * SAMPLE_BITS + 1;

	logic              push, pop;
	logic [ITEM_W-1:0] push_data, head;
	fmmn_qstat_t       qstat;

	// front: bank write, min/max tracking, previous-frame readback
	fmmn_front #(
		.FRAME_LEN   (FRAME_LEN),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	// decouples the front, one sample per cycle while the queue has room, from the serial back end
	fmmn_queue #(
		.WIDTH (ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// back: divider and result register
	fmmn_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.results (results)
	);

endmodule

// ===== rtl/fmmn_checker.sv =====
// ----------------------------------------------------------------------------
// fmmn_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
module fmmn_checker
	import fmmn_pkg::*;
	#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [FRACTION_BITS:0] normalized,
	input logic                   frame_last
);

	logic out_xfer;

	assign out_xfer = out_valid && out_ready;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(normalized) && $stable(frame_last))
		else $error("result changed while stalled");

	// normalized value never exceeds one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normalized <= (FRACTION_BITS + 1)'(1) << FRACTION_BITS)
		else $error("normalized value above full scale");

	// a frame has at least two samples, so two back-to-back transfers are not
	// both frame ends
	a_last_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && frame_last |=> !(out_xfer && frame_last))
		else $error("back-to-back frame ends");

endmodule

bind frame_min_max_normalizer fmmn_checker #(
	.FRACTION_BITS (FRACTION_BITS)
) u_fmmn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.normalized (results.normalized),
	.frame_last (results.frame_last)
);
